@@ src/sbm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types, register codes and helpers for the serial bank mapper.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // Configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  localparam int unsigned PRG_COUNT_W = 6;
  localparam int unsigned CHR_COUNT_W = 5;
  localparam int unsigned BANK_W      = 5;
  localparam int unsigned CFG_DATA_W  = 6;

  // Reset values of the configuration registers
  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RST = 6'd2;
  localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RST = 5'd1;

  // Mapper register selected by address bits 14:13
  typedef enum logic [1:0] {
    REG_CONTROL   = 2'd0,
    REG_CHR_PAGE0 = 2'd1,
    REG_CHR_PAGE1 = 2'd2,
    REG_PRG_PAGE  = 2'd3
  } reg_sel_t;

  // PRG modes; codes 0 and 1 both mean 32 KB switching
  localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  typedef struct packed {
    logic [1:0]        mirroring;
    logic [1:0]        prg_mode;
    logic              chr_split;
    logic [BANK_W-1:0] prg_lo;
    logic [BANK_W-1:0] prg_hi;
    logic [BANK_W-1:0] chr_lo;
    logic [BANK_W-1:0] chr_hi;
    logic [2:0]        shift_count;
    logic [4:0]        shift_value;
  } map_state_t;

  // Last 16 KB bank, count minus one wrapped to the bank field
  function automatic logic [BANK_W-1:0] last_bank(input logic [PRG_COUNT_W-1:0] cnt);
    logic [PRG_COUNT_W-1:0] diff;
    diff = cnt - PRG_COUNT_W'(1);
    return diff[BANK_W-1:0];
  endfunction

endpackage

@@ src/sbm_in_if.sv @@
// ----------------------------------------------------------------------------
// sbm_in_if
// CPU write channel: valid/ready handshake with address and data.
// ----------------------------------------------------------------------------
interface sbm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cpu_address;
  logic [7:0]  cpu_data;

  modport source (output valid, output cpu_address, output cpu_data, input ready);
  modport sink   (input valid, input cpu_address, input cpu_data, output ready);
endinterface

@@ src/sbm_out_if.sv @@
// ----------------------------------------------------------------------------
// sbm_out_if
// Mapping result channel: valid/ready handshake with the current mapping.
// ----------------------------------------------------------------------------
interface sbm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mirroring_mode;
  logic [1:0] prg_mode_out;
  logic       chr_split_mode;
  logic [4:0] prg_lower_bank;
  logic [4:0] prg_upper_bank;
  logic [4:0] chr_lower_bank;
  logic [4:0] chr_upper_bank;
  logic [2:0] bits_shifted;
  logic       register_committed;

  modport source (
    output valid, output mirroring_mode, output prg_mode_out, output chr_split_mode,
    output prg_lower_bank, output prg_upper_bank, output chr_lower_bank,
    output chr_upper_bank, output bits_shifted, output register_committed,
    input ready
  );
  modport sink (
    input valid, input mirroring_mode, input prg_mode_out, input chr_split_mode,
    input prg_lower_bank, input prg_upper_bank, input chr_lower_bank,
    input chr_upper_bank, input bits_shifted, input register_committed,
    output ready
  );
endinterface

@@ src/sbm_update.sv @@
// ----------------------------------------------------------------------------
// sbm_update
// Next-state logic for one CPU write: serial shift, clear and register commit.
// ----------------------------------------------------------------------------
module sbm_update (
  input  sbm_pkg::map_state_t               cur,
  input  logic [15:0]                       cpu_address,
  input  logic [7:0]                        cpu_data,
  input  logic [sbm_pkg::PRG_COUNT_W-1:0]   prg_bank_count,
  input  logic [sbm_pkg::CHR_COUNT_W-1:0]   chr_bank_count,
  output sbm_pkg::map_state_t               nxt,
  output logic                              committed
);

  logic [4:0]                       load_val;
  logic [4:0]                       chr_page;
  logic [sbm_pkg::CHR_COUNT_W:0]    chr_units;
  logic [sbm_pkg::BANK_W-1:0]       last;
  sbm_pkg::reg_sel_t                sel;

  assign load_val  = {cpu_data[0], cur.shift_value[3:0]};
  assign chr_page  = cur.chr_split ? load_val : {load_val[4:1], 1'b0};
  assign chr_units = {chr_bank_count, 1'b0};  // 4 KB banks
  assign last      = sbm_pkg::last_bank(prg_bank_count);
  assign sel       = sbm_pkg::reg_sel_t'(cpu_address[14:13]);

  always_comb begin
    nxt       = cur;
    committed = 1'b0;
    if (cpu_address[15]) begin
      if (cpu_data[7]) begin
        nxt.shift_count = 3'd0;
        nxt.shift_value = 5'd0;
        nxt.prg_mode    = sbm_pkg::PRG_MODE_FIX_HIGH;
        nxt.prg_hi      = last;
      end else if (cur.shift_count == 3'd4) begin
        nxt.shift_count = 3'd0;
        nxt.shift_value = 5'd0;
        committed       = 1'b1;
        case (sel)
          sbm_pkg::REG_CONTROL: begin
            nxt.mirroring = load_val[1:0];
            nxt.prg_mode  = load_val[3:2];
            nxt.chr_split = load_val[4];
          end
          sbm_pkg::REG_CHR_PAGE0: begin
            if ({1'b0, chr_page} < chr_units) begin
              nxt.chr_lo = chr_page;
              if (!cur.chr_split) begin
                nxt.chr_hi = chr_page | 5'd1;
              end
            end
          end
          sbm_pkg::REG_CHR_PAGE1: begin
            if (cur.chr_split && ({1'b0, load_val} < chr_units)) begin
              nxt.chr_hi = load_val;
            end
          end
          sbm_pkg::REG_PRG_PAGE: begin
            case (cur.prg_mode)
              sbm_pkg::PRG_MODE_FIX_LOW: begin
                nxt.prg_lo = 5'd0;
                nxt.prg_hi = {1'b0, load_val[3:0]};
              end
              sbm_pkg::PRG_MODE_FIX_HIGH: begin
                nxt.prg_lo = {1'b0, load_val[3:0]};
                nxt.prg_hi = last;
              end
              default: begin
                // 32 KB switching: even/odd pair
                nxt.prg_lo = {1'b0, load_val[3:1], 1'b0};
                nxt.prg_hi = {1'b0, load_val[3:1], 1'b1};
              end
            endcase
          end
          default: begin
            nxt = cur;
          end
        endcase
      end else begin
        nxt.shift_value = cur.shift_value | (5'(cpu_data[0]) << cur.shift_count);
        nxt.shift_count = cur.shift_count + 3'd1;
      end
    end
  end

endmodule

@@ src/serial_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// serial_bank_mapper
// Serial-load bank mapper: CPU writes in, one mapping snapshot out per write.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries CPU writes (cpu_address, cpu_data). Writes at 0x8000 and up
//   drive the five-bit serial loader; lower addresses pass through unchanged.
//   Every accepted write yields exactly one result on out_ch holding the
//   mirroring, PRG mode, CHR split mode, the four window banks, the count of
//   serial bits held and a flag for a completed register load.
//   The cfg port sets the PRG and CHR bank counts; write it only while idle.
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one write per cycle; the state update is a single pass of
//   logic on small registers, and the result register holds while out_ch
//   stalls. in_ch.ready stays high while the result register is empty or
//   being drained, so a stalled receiver holds off the input by one result.
//   Reset (rst_n low, synchronous): PRG count 2, CHR count 1, serial loader
//   empty, PRG mode 3, 4 KB CHR mode, windows PRG 0/1 and CHR 0/1, no result.
// ----------------------------------------------------------------------------
module serial_bank_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  sbm_in_if.sink                           in_ch,
  sbm_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [sbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sbm_pkg::map_state_t                   state_r;
  sbm_pkg::map_state_t                   state_nxt;
  sbm_pkg::map_state_t                   res_r;
  logic                                  committed_nxt;
  logic                                  committed_r;
  logic                                  out_valid_r;
  logic [sbm_pkg::PRG_COUNT_W-1:0]       prg_count_r;
  logic [sbm_pkg::CHR_COUNT_W-1:0]       chr_count_r;
  logic                                  in_xfer;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  sbm_update u_update (
    .cur            (state_r),
    .cpu_address    (in_ch.cpu_address),
    .cpu_data       (in_ch.cpu_data),
    .prg_bank_count (prg_count_r),
    .chr_bank_count (chr_count_r),
    .nxt            (state_nxt),
    .committed      (committed_nxt)
  );

  // Mapper state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r           <= sbm_pkg::PRG_COUNT_RST;
      chr_count_r           <= sbm_pkg::CHR_COUNT_RST;
      state_r.mirroring     <= 2'd0;
      state_r.prg_mode      <= sbm_pkg::PRG_MODE_FIX_HIGH;
      state_r.chr_split     <= 1'b1;
      state_r.prg_lo        <= 5'd0;
      state_r.prg_hi        <= sbm_pkg::last_bank(sbm_pkg::PRG_COUNT_RST);
      state_r.chr_lo        <= 5'd0;
      state_r.chr_hi        <= 5'd1;
      state_r.shift_count   <= 3'd0;
      state_r.shift_value   <= 5'd0;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end else if (cfg_we) begin
      if (cfg_index == sbm_pkg::CFG_PRG_BANK_COUNT) begin
        prg_count_r    <= cfg_wdata;
        // a new count re-pins the upper window to the last bank
        state_r.prg_hi <= sbm_pkg::last_bank(cfg_wdata);
      end else begin
        chr_count_r <= cfg_wdata[sbm_pkg::CHR_COUNT_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r       <= state_nxt;
      committed_r <= committed_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.mirroring_mode     = res_r.mirroring;
  assign out_ch.prg_mode_out       = res_r.prg_mode;
  assign out_ch.chr_split_mode     = res_r.chr_split;
  assign out_ch.prg_lower_bank     = res_r.prg_lo;
  assign out_ch.prg_upper_bank     = res_r.prg_hi;
  assign out_ch.chr_lower_bank     = res_r.chr_lo;
  assign out_ch.chr_upper_bank     = res_r.chr_hi;
  assign out_ch.bits_shifted       = res_r.shift_count;
  assign out_ch.register_committed = committed_r;

endmodule

@@ src/sbm_checker.sv @@
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks for the serial bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
module sbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mirroring_mode,
  input logic [1:0] prg_mode_out,
  input logic       chr_split_mode,
  input logic [4:0] prg_lower_bank,
  input logic [4:0] prg_upper_bank,
  input logic [4:0] chr_lower_bank,
  input logic [4:0] chr_upper_bank,
  input logic [2:0] bits_shifted,
  input logic       register_committed
);

  logic [28:0] payload;
  assign payload = {mirroring_mode, prg_mode_out, chr_split_mode, prg_lower_bank,
                    prg_upper_bank, chr_lower_bank, chr_upper_bank, bits_shifted,
                    register_committed};

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload))
    else $error("result changed while stalled");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // loader never holds five bits
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bits_shifted <= 3'd4)
    else $error("serial bit count out of range");

  // a completed load leaves the loader empty
  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && register_committed |-> bits_shifted == 3'd0)
    else $error("commit left serial bits behind");

  // an input transfer always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer produced no result");

endmodule

bind serial_bank_mapper sbm_checker u_sbm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .mirroring_mode     (out_ch.mirroring_mode),
  .prg_mode_out       (out_ch.prg_mode_out),
  .chr_split_mode     (out_ch.chr_split_mode),
  .prg_lower_bank     (out_ch.prg_lower_bank),
  .prg_upper_bank     (out_ch.prg_upper_bank),
  .chr_lower_bank     (out_ch.chr_lower_bank),
  .chr_upper_bank     (out_ch.chr_upper_bank),
  .bits_shifted       (out_ch.bits_shifted),
  .register_committed (out_ch.register_committed)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for serial_bank_mapper. A table of directed CPU writes is
// followed by random five-bit serial loads, clears and ignored writes under
// several bank-count settings and idle/stall patterns. Every result transfer is
// compared field by field against its table value or an in-bench mapper model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_WRITES = 125;
  localparam int unsigned N_DIRECTED   = 26;

  typedef struct packed {
    logic [1:0]                 mirroring;
    logic [1:0]                 prg_mode;
    logic                       chr_split;
    logic [sbm_pkg::BANK_W-1:0] prg_lo;
    logic [sbm_pkg::BANK_W-1:0] prg_hi;
    logic [sbm_pkg::BANK_W-1:0] chr_lo;
    logic [sbm_pkg::BANK_W-1:0] chr_hi;
    logic [2:0]                 shifted;
    logic                       committed;
  } mapping_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic        fixed;
    mapping_t    want;
  } write_row_t;

  localparam mapping_t RESET_VIEW = '{2'd0, sbm_pkg::PRG_MODE_FIX_HIGH, 1'b1,
                                      5'd0, 5'd1, 5'd0, 5'd1, 3'd0, 1'b0};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [sbm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sbm_in_if  wr_ch ();
  sbm_out_if map_ch ();

  serial_bank_mapper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (wr_ch),
    .out_ch    (map_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Model state
  logic [sbm_pkg::PRG_COUNT_W-1:0] m_prg_cnt;
  logic [sbm_pkg::CHR_COUNT_W-1:0] m_chr_cnt;
  logic [2:0]                      m_shift_n;
  logic [4:0]                      m_shift_v;
  logic [4:0]                      m_ctrl;
  logic [4:0]                      m_chr_pg0;
  logic [4:0]                      m_chr_pg1;
  logic [4:0]                      m_prg_pg;
  logic [1:0]                      m_prg_mode;
  logic                            m_chr_split;
  logic [sbm_pkg::BANK_W-1:0]      m_prg_lo, m_prg_hi, m_chr_lo, m_chr_hi;

  mapping_t expected_maps[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned mapper_writes = 0;
  int unsigned ignored_writes = 0;
  int unsigned loads_done    = 0;
  int unsigned clears_done   = 0;
  int unsigned quiet_cycles  = 0;

  write_row_t directed_writes [N_DIRECTED] = '{
    '{16'h0000, 8'hFF, 1'b1, RESET_VIEW},
    '{16'h7FFF, 8'h01, 1'b1, RESET_VIEW},
    '{16'h8000, 8'h80, 1'b1, RESET_VIEW},
    '{16'hFFFF, 8'hFF, 1'b1, RESET_VIEW},
    // control <= 5'b00011: horizontal, 32 KB PRG, 8 KB CHR
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'hA000, 8'h7F, 1'b0, '0},
    '{16'hC000, 8'h00, 1'b0, '0},
    '{16'hE000, 8'h7E, 1'b0, '0},
    '{16'h9FFF, 8'h00, 1'b0, '0},
    // CHR page 1 <= 5'b11111, only stored in 4 KB mode
    '{16'h8001, 8'h01, 1'b0, '0},
    '{16'h8002, 8'h03, 1'b0, '0},
    '{16'h8004, 8'h55, 1'b0, '0},
    '{16'h8008, 8'h2B, 1'b0, '0},
    '{16'hC000, 8'h7F, 1'b0, '0},
    // CHR page 0 <= 5'b00011, masked to 2, out of range with one 8 KB bank
    '{16'hFFFF, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h00, 1'b0, '0},
    '{16'h8000, 8'h00, 1'b0, '0},
    '{16'hBFFF, 8'h00, 1'b0, '0},
    // PRG page <= 5'b10111 in 32 KB mode: banks 6/7
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h40, 1'b0, '0},
    '{16'hE000, 8'h01, 1'b0, '0},
    // partial load cut short by a clear
    '{16'h8000, 8'h01, 1'b0, '0},
    '{16'h8000, 8'h80, 1'b0, '0}
  };

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [sbm_pkg::BANK_W-1:0] top_prg_bank();
    return m_prg_cnt[sbm_pkg::BANK_W-1:0] - 5'd1;
  endfunction

  function automatic mapping_t mapper_step(input logic [15:0] addr,
                                           input logic [7:0] data);
    logic [5:0] chr_units;
    logic       loaded;
    chr_units = {m_chr_cnt, 1'b0};
    loaded    = 1'b0;
    if (addr[15]) begin
      if (data[7]) begin
        m_shift_n  = 3'd0;
        m_shift_v  = 5'd0;
        m_ctrl[3:2] = 2'b11;
        m_prg_mode = sbm_pkg::PRG_MODE_FIX_HIGH;
        m_prg_hi   = top_prg_bank();
      end else begin
        m_shift_v[m_shift_n] = data[0];
        m_shift_n = m_shift_n + 3'd1;
        if (m_shift_n == 3'd5) begin
          loaded = 1'b1;
          case (sbm_pkg::reg_sel_t'(addr[14:13]))
            sbm_pkg::REG_CONTROL: begin
              m_ctrl      = m_shift_v;
              m_prg_mode  = m_shift_v[3:2];
              m_chr_split = m_shift_v[4];
            end
            sbm_pkg::REG_CHR_PAGE0: begin
              m_chr_pg0 = m_chr_split ? m_shift_v : {m_shift_v[4:1], 1'b0};
              if (chr_units != 6'd0 && {1'b0, m_chr_pg0} < chr_units) begin
                m_chr_lo = m_chr_pg0;
                if (!m_chr_split) m_chr_hi = {m_chr_pg0[4:1], 1'b1};
              end
            end
            sbm_pkg::REG_CHR_PAGE1: begin
              m_chr_pg1 = m_shift_v;
              if (m_chr_split && chr_units != 6'd0 && {1'b0, m_chr_pg1} < chr_units)
                m_chr_hi = m_chr_pg1;
            end
            default: begin
              if (m_prg_mode < sbm_pkg::PRG_MODE_FIX_LOW) begin
                m_prg_pg = {1'b0, m_shift_v[3:1], 1'b0};
                m_prg_lo = m_prg_pg;
                m_prg_hi = {m_prg_pg[4:1], 1'b1};
              end else if (m_prg_mode == sbm_pkg::PRG_MODE_FIX_LOW) begin
                m_prg_pg = {1'b0, m_shift_v[3:0]};
                m_prg_lo = 5'd0;
                m_prg_hi = m_prg_pg;
              end else begin
                m_prg_pg = {1'b0, m_shift_v[3:0]};
                m_prg_lo = m_prg_pg;
                m_prg_hi = top_prg_bank();
              end
            end
          endcase
          m_shift_n = 3'd0;
          m_shift_v = 5'd0;
        end
      end
    end
    return '{m_ctrl[1:0], m_prg_mode, m_chr_split, m_prg_lo, m_prg_hi,
             m_chr_lo, m_chr_hi, m_shift_n, loaded};
  endfunction

  function automatic string map_text(input mapping_t m);
    return $sformatf("mir=%0d prg_mode=%0d split=%0d prg=%0d/%0d chr=%0d/%0d bits=%0d load=%0d",
                     m.mirroring, m.prg_mode, m.chr_split, m.prg_lo, m.prg_hi,
                     m.chr_lo, m.chr_hi, m.shifted, m.committed);
  endfunction

  // One CPU write transfer; the expectation is pushed at the accepting edge.
  task automatic send_write(input logic [15:0] addr, input logic [7:0] data,
                            input logic fixed = 1'b0, input mapping_t want = '0);
    int unsigned gap;
    mapping_t    pred;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      wr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    wr_ch.valid       <= 1'b1;
    wr_ch.cpu_address <= addr;
    wr_ch.cpu_data    <= data;
    do @(posedge clk); while (!wr_ch.ready);
    pred = mapper_step(addr, data);
    expected_maps.push_back(fixed ? want : pred);
    if (!addr[15]) ignored_writes++;
    else mapper_writes++;
    if (addr[15] && data[7]) clears_done++;
    if (pred.committed) loads_done++;
  endtask

  task automatic drain_results();
    wr_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_maps.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_bank_counts(input logic [sbm_pkg::PRG_COUNT_W-1:0] prg_cnt,
                                 input logic [sbm_pkg::CHR_COUNT_W-1:0] chr_cnt);
    cfg_we    <= 1'b1;
    cfg_index <= sbm_pkg::CFG_PRG_BANK_COUNT;
    cfg_wdata <= prg_cnt;
    @(posedge clk);
    cfg_index <= sbm_pkg::CFG_CHR_BANK_COUNT;
    cfg_wdata <= sbm_pkg::CFG_DATA_W'(chr_cnt);
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_prg_cnt = prg_cnt;
    m_prg_hi  = top_prg_bank();
    m_chr_cnt = chr_cnt;
  endtask

  function automatic logic [7:0] clear_byte();
    return {1'b1, 7'($urandom)};
  endfunction

  // Mostly complete five-bit loads with random content; the rest is noise.
  task automatic random_traffic(input int unsigned n_writes);
    int unsigned       done;
    int unsigned       pick;
    int unsigned       nbits;
    logic [4:0]        val;
    sbm_pkg::reg_sel_t tgt;
    logic [15:0]       a;
    done = 0;
    while (done < n_writes) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_write({1'b0, 15'($urandom)}, 8'($urandom));
        done++;
      end else if (pick < 14) begin
        send_write({1'b1, 15'($urandom)}, clear_byte());
        done++;
      end else begin
        nbits = (pick < 22) ? $urandom_range(1, 4) : 5;
        tgt   = sbm_pkg::reg_sel_t'(2'($urandom_range(3)));
        val   = 5'($urandom);
        for (int i = 0; i < nbits; i++) begin
          a = {1'b1, 15'($urandom)};
          if (i == 4) a[14:13] = tgt;
          send_write(a, {1'b0, 6'($urandom), val[i]});
          done++;
        end
        if (nbits < 5) begin
          send_write({1'b1, 15'($urandom)}, clear_byte());
          done++;
        end
      end
    end
  endtask

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin : receiver
    map_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        map_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      map_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    mapping_t got;
    mapping_t want;
    if (rst_n && map_ch.valid && map_ch.ready) begin
      got = '{map_ch.mirroring_mode, map_ch.prg_mode_out, map_ch.chr_split_mode,
              map_ch.prg_lower_bank, map_ch.prg_upper_bank, map_ch.chr_lower_bank,
              map_ch.chr_upper_bank, map_ch.bits_shifted, map_ch.register_committed};
      results_seen++;
      if (expected_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no write pending: %s", map_text(got));
      end else begin
        want = expected_maps.pop_front();
        if (got.mirroring !== want.mirroring || got.prg_mode !== want.prg_mode ||
            got.chr_split !== want.chr_split || got.prg_lo !== want.prg_lo ||
            got.prg_hi !== want.prg_hi || got.chr_lo !== want.chr_lo ||
            got.chr_hi !== want.chr_hi || got.shifted !== want.shifted ||
            got.committed !== want.committed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d mismatch", results_seen);
            $display("  expected %s", map_text(want));
            $display("  actual   %s", map_text(got));
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((wr_ch.valid && wr_ch.ready) || (map_ch.valid && map_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_maps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [sbm_pkg::PRG_COUNT_W-1:0] prg_counts [PHASES];
    logic [sbm_pkg::CHR_COUNT_W-1:0] chr_counts [PHASES];
    int unsigned                     idle_mode;
    prg_counts = '{6'd1, 6'd32, 6'd0, 6'd63, 6'($urandom), 6'd17};
    chr_counts = '{5'd0, 5'd16, 5'd31, 5'd8, 5'($urandom_range(16)), 5'd3};

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = sbm_pkg::CFG_PRG_BANK_COUNT;
    cfg_wdata         = '0;
    wr_ch.valid       = 1'b0;
    wr_ch.cpu_address = '0;
    wr_ch.cpu_data    = '0;

    m_prg_cnt   = sbm_pkg::PRG_COUNT_RST;
    m_chr_cnt   = sbm_pkg::CHR_COUNT_RST;
    m_shift_n   = 3'd0;
    m_shift_v   = 5'd0;
    m_ctrl      = 5'd0;
    m_chr_pg0   = 5'd0;
    m_chr_pg1   = 5'd0;
    m_prg_pg    = 5'd0;
    m_prg_mode  = sbm_pkg::PRG_MODE_FIX_HIGH;
    m_chr_split = 1'b1;
    m_prg_lo    = 5'd0;
    m_prg_hi    = top_prg_bank();
    m_chr_lo    = 5'd0;
    m_chr_hi    = 5'd1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed writes at the reset bank counts
    for (int r = 0; r < N_DIRECTED; r++)
      send_write(directed_writes[r].addr, directed_writes[r].data,
                 directed_writes[r].fixed, directed_writes[r].want);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      idle_mode = p % 4;
      send_idle_pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 8 : 0;
      stall_pct     = (idle_mode == 2) ? 72 : (idle_mode == 3) ? 8 : 0;
      set_bank_counts(prg_counts[p], chr_counts[p]);
      random_traffic(PHASE_WRITES / 2);
      if (idle_mode == 0) hold_requests++;       // sender keeps going into a stalled output
      if (idle_mode == 3) drain_results();       // sender pauses until all results are back
      random_traffic(PHASE_WRITES - PHASE_WRITES / 2);
      drain_results();
    end

    repeat (4) @(posedge clk);
    $display("Covered %0d mapper writes and %0d ignored writes: %0d register loads, %0d clears",
             mapper_writes, ignored_writes, loads_done, clears_done);
    $display("Checked %0d results over %0d bank-count settings, %0d mismatches",
             results_seen, PHASES + 1, mismatches);
    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
